@@ design/egcd_pkg.sv @@
// Shared constants and controller/datapath interface types for the extended gcd block.
package egcd_pkg;

  localparam int OPERAND_WIDTH = 31;
  localparam int IN_W          = 31;
  localparam int GCD_W         = 31;
  localparam int COEF_W        = 32;
  localparam int CNT_W         = $clog2(OPERAND_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_UPD,
    S_OUT
  } egcd_state_e;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic update;
  } egcd_cmd_t;

  typedef struct packed {
    logic rcur_zero;
  } egcd_stat_t;

endpackage

@@ design/extended_gcd_bezout.sv @@
// Top level of the extended gcd block: gcd and Bezout coefficients of two operands.
//
// Usage:
//   Request channel: drive a_value_i and b_value_i and raise start. The request
//   is taken at the rising edge where start is high and busy is low; busy then
//   stays high until the result has gone out. Hold start low or ignore it
//   while busy - nothing is queued.
//   Result channel: done_o pulses for exactly one cycle with gcd_value_o,
//   coef_u_o and coef_v_o valid, a_value*coef_u + b_value*coef_v = gcd_value.
//   The receiver cannot stall; sample the result in the done_o cycle.
//   Each request runs n Euclid steps between acceptance and done_o, where n is
//   at most about 46 for 31-bit operands. Each step runs the bit-serial
//   restoring divider, one quotient bit per cycle, with both q*coef products
//   built alongside it; one request is in flight at a time.
//   b_value of zero gives gcd = a_value, u = 1, v = 0 with no divide step.
//   Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
//   any request in progress; no result is produced for it.
module extended_gcd_bezout (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [egcd_pkg::IN_W-1:0]          a_value_i,
  input  logic [egcd_pkg::IN_W-1:0]          b_value_i,
  output logic                               done_o,
  output logic [egcd_pkg::GCD_W-1:0]         gcd_value_o,
  output logic signed [egcd_pkg::COEF_W-1:0] coef_u_o,
  output logic signed [egcd_pkg::COEF_W-1:0] coef_v_o
);
  import egcd_pkg::*;

  egcd_cmd_t  cmd;
  egcd_stat_t stat;

  // Sequencer: load, divide, update, repeat until the remainder is zero.
  egcd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // Datapath: holds the remainder and coefficient pairs; outputs read the
  // "previous" registers directly, which hold the answer when done_o pulses.
  egcd_dp u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .a_value_i   (a_value_i),
    .b_value_i   (b_value_i),
    .stat_o      (stat),
    .gcd_value_o (gcd_value_o),
    .coef_u_o    (coef_u_o),
    .coef_v_o    (coef_v_o)
  );

  // An accepted request makes the block busy on the next cycle.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  // A result only appears while a request is in flight.
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // The result strobe lasts one cycle and frees the block.
  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe longer than one cycle");

  // A zero gcd only comes from two zero operands, giving u = 1, v = 0.
  a_zero_gcd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && gcd_value_o == '0) |-> (coef_u_o == COEF_W'(1) && coef_v_o == '0))
    else $error("bad coefficients for zero gcd");

endmodule

@@ design/egcd_ctrl.sv @@
// Sequencer for the extended gcd block: steps the Euclid loop and its bit-serial divide.
module egcd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  egcd_pkg::egcd_stat_t stat_i,
  output egcd_pkg::egcd_cmd_t  cmd_o,
  output logic              busy,
  output logic              done_o
);
  import egcd_pkg::*;

  egcd_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.rcur_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(OPERAND_WIDTH - 1)) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_CHECK;
      end
      S_OUT: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/egcd_dp.sv @@
// Datapath: remainder pair, coefficient pairs, restoring divider and Horner multiply-accumulate.
module egcd_dp (
  input  logic                          clk_i,
  input  egcd_pkg::egcd_cmd_t           cmd_i,
  input  logic [egcd_pkg::IN_W-1:0]     a_value_i,
  input  logic [egcd_pkg::IN_W-1:0]     b_value_i,
  output egcd_pkg::egcd_stat_t          stat_o,
  output logic [egcd_pkg::GCD_W-1:0]    gcd_value_o,
  output logic signed [egcd_pkg::COEF_W-1:0] coef_u_o,
  output logic signed [egcd_pkg::COEF_W-1:0] coef_v_o
);
  import egcd_pkg::*;

  localparam int W = OPERAND_WIDTH;

  logic [W-1:0]      r_prev_q, r_cur_q, rem_q, dvd_q;
  logic [COEF_W-1:0] u_prev_q, u_cur_q, v_prev_q, v_cur_q, acc_u_q, acc_v_q;

  logic [W:0]   shifted;
  logic [W+1:0] diff;
  logic         qbit;

  // One restoring divide step: shift in the next dividend bit, try the subtract.
  assign shifted = {rem_q, dvd_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, r_cur_q};
  assign qbit    = ~diff[W+1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_prev_q <= W'(a_value_i);
      r_cur_q  <= W'(b_value_i);
      u_prev_q <= COEF_W'(1);
      u_cur_q  <= '0;
      v_prev_q <= '0;
      v_cur_q  <= COEF_W'(1);
    end else if (cmd_i.update) begin
      r_prev_q <= r_cur_q;
      r_cur_q  <= rem_q;
      u_prev_q <= u_cur_q;
      u_cur_q  <= u_prev_q - acc_u_q;
      v_prev_q <= v_cur_q;
      v_cur_q  <= v_prev_q - acc_v_q;
    end

    if (cmd_i.div_init) begin
      rem_q   <= '0;
      dvd_q   <= r_prev_q;
      acc_u_q <= '0;
      acc_v_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q   <= qbit ? diff[W-1:0] : shifted[W-1:0];
      dvd_q   <= {dvd_q[W-2:0], 1'b0};
      // Quotient bits arrive MSB first: acc = 2*acc + bit*coef builds q*coef.
      acc_u_q <= {acc_u_q[COEF_W-2:0], 1'b0} + (qbit ? u_cur_q : '0);
      acc_v_q <= {acc_v_q[COEF_W-2:0], 1'b0} + (qbit ? v_cur_q : '0);
    end
  end

  assign stat_o.rcur_zero = (r_cur_q == '0);
  assign gcd_value_o      = GCD_W'(r_prev_q);
  assign coef_u_o         = u_prev_q;
  assign coef_v_o         = v_prev_q;

endmodule
